@@ hw/rtl/tapr_pkg.sv @@
// Package of the torus point renderer: grid and loop constants, command codes,
// the datapath micro-operations, controller/datapath structs and small tables.
// No dependencies.
`default_nettype none
package tapr_pkg;

  localparam int COLS       = 80;
  localparam int ROWS       = 22;
  localparam int CELLS      = COLS * ROWS;
  localparam int RING_STEPS = 324;
  localparam int TUBE_STEPS = 90;
  localparam int DEPTH_BASE = 1280;
  localparam int CENTRE_X   = COLS / 2;
  localparam int CENTRE_Y   = (ROWS + 2) / 2;

  localparam int IDX_W  = 11;
  localparam int CMD_W  = 2;
  localparam int RING_W = 9;
  localparam int TUBE_W = 7;

  localparam logic [CMD_W-1:0] CMD_PLOT  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME = 2'd2;

  localparam logic [7:0]        CHAR_SPACE = 8'd32;
  localparam logic [7:0]        CHAR_NL    = 8'd10;
  localparam logic signed [7:0] DEPTH_FAR  = 8'sd127;
  localparam logic signed [7:0] UNIT       = 8'sd16;

  typedef enum logic [5:0] {
    OP_NONE, OP_LATCH,
    OP_X1, OP_X2, OP_X3, OP_X4, OP_X5, OP_X6, OP_X7,
    OP_NXA, OP_NXB, OP_NYA, OP_NYB,
    OP_L1, OP_L2, OP_L3, OP_L4, OP_L5, OP_L6,
    OP_R1, OP_R2, OP_R3, OP_R4, OP_R5,
    OP_DIVX_GET, OP_DIVY_GET, OP_MRD_PLOT, OP_MWR_PLOT,
    OP_RING_ADV, OP_MRD_CELL, OP_CELL_OUT, OP_FRAME, OP_CLR
  } dp_op_t;

  typedef enum logic [1:0] {ROT_RING, ROT_TUBE, ROT_VA, ROT_VB} rot_sel_t;

  typedef struct packed {
    dp_op_t   op;
    rot_sel_t rot;
    logic     div_start;
    logic     div_y;
    logic     load_out;
  } dp_ctrl_t;

  typedef struct packed {
    logic x6_zero;
    logic in_grid;
    logic div_done;
    logic ring_wrap;
    logic clr_last;
    logic frame_done;
  } dp_stat_t;

  localparam logic [4:0] PLOT_LAST = 5'd16;
  localparam logic [4:0] ROT_LAST  = 5'd4;

  function automatic dp_op_t plot_op(input logic [4:0] step);
    dp_op_t op;
    case (step)
      5'd0:    op = OP_X1;
      5'd1:    op = OP_X2;
      5'd2:    op = OP_X3;
      5'd3:    op = OP_X4;
      5'd4:    op = OP_X5;
      5'd5:    op = OP_X6;
      5'd6:    op = OP_X7;
      5'd7:    op = OP_NXA;
      5'd8:    op = OP_NXB;
      5'd9:    op = OP_NYA;
      5'd10:   op = OP_NYB;
      5'd11:   op = OP_L1;
      5'd12:   op = OP_L2;
      5'd13:   op = OP_L3;
      5'd14:   op = OP_L4;
      5'd15:   op = OP_L5;
      5'd16:   op = OP_L6;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic dp_op_t rot_op(input logic [4:0] step);
    dp_op_t op;
    case (step)
      5'd0:    op = OP_R1;
      5'd1:    op = OP_R2;
      5'd2:    op = OP_R3;
      5'd3:    op = OP_R4;
      5'd4:    op = OP_R5;
      default: op = OP_NONE;
    endcase
    return op;
  endfunction

  function automatic logic [7:0] shade_char(input logic [3:0] n);
    logic [7:0] c;
    case (n)
      4'd0:    c = "0";
      4'd1:    c = ",";
      4'd2:    c = "-";
      4'd3:    c = "~";
      4'd4:    c = ":";
      4'd5:    c = ";";
      4'd6:    c = "=";
      4'd7:    c = "!";
      4'd8:    c = "*";
      4'd9:    c = "#";
      4'd10:   c = "$";
      default: c = "@";
    endcase
    return c;
  endfunction

  // True when the index falls in column zero of some row, also past the grid.
  function automatic logic col_zero(input logic [IDX_W-1:0] idx);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k <= ((1 << IDX_W) - 1) / COLS; k++) begin
      if (idx == IDX_W'(k * COLS)) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/tapr_if.sv @@
// Stream interfaces of the torus point renderer: command channel and result channel.
// Depends on tapr_pkg.
`default_nettype none
interface tapr_req_if;
  import tapr_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [IDX_W-1:0] cell_index;
  modport source (output valid, cmd, cell_index, input ready);
  modport sink (input valid, cmd, cell_index, output ready);
endinterface

interface tapr_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] cell_char;
  logic       plotted;
  logic       frame_done;
  modport source (output valid, cell_char, plotted, frame_done, input ready);
  modport sink (input valid, cell_char, plotted, frame_done, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/torus_ascii_point_renderer.sv @@
// Plot: 17 steps of multiplies and shading, two divisions on the shared divider, memory
// read/write, a 5-step ring rotation and, when the ring wraps, a tube rotation; off-grid
// points skip the memory, zero depth also the divisions. Read: fetches one cell. Next frame:
// view rotations, loop reset, clearing pass. Other codes reply. One command at a time;
// a result may wait in the output register while the next command is accepted.
// Synchronous reset starts a cell-memory clearing pass during which no command is accepted.
`default_nettype none
module torus_ascii_point_renderer (
  input  logic      clk,
  input  logic      rst,
  tapr_req_if.sink  req,
  tapr_rsp_if.source rsp
);
  import tapr_pkg::*;

  // The controller owns the handshakes and sequencing; the datapath holds all
  // arithmetic state, the cell memory and the registered result beat.
  dp_ctrl_t ctrl;
  dp_stat_t stat;

  tapr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_cmd   (req.cmd),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // The result payload stays in the datapath output register until the beat
  // is taken, so a new command can run while it waits.
  tapr_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .req_index  (req.cell_index),
    .stat       (stat),
    .cell_char  (rsp.cell_char),
    .plotted    (rsp.plotted),
    .frame_done (rsp.frame_done)
  );
endmodule
`default_nettype wire

@@ hw/rtl/tapr_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on nothing but its ports.
`default_nettype none
module tapr_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [31:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);
  logic        busy;
  logic [4:0]  cnt;
  logic [32:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic        neg;
  logic [32:0] rem_sh;

  assign rem_sh   = {rem[31:0], quo[31]};
  assign quotient = neg ? -$signed(quo) : $signed(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == 5'd31);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend[31] ? 32'(-dividend) : 32'(dividend);
        dvs  <= divisor[31] ? 32'(-divisor) : 32'(divisor);
        neg  <= dividend[31] ^ divisor[31];
      end else if (busy) begin
        if (rem_sh >= {1'b0, dvs}) begin
          rem <= rem_sh - {1'b0, dvs};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[30:0], 1'b0};
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) busy <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/tapr_datapath.sv @@
// Datapath: angle registers, shared multiplier, divider, cell memory, result registers.
// Depends on tapr_pkg and tapr_div.
`default_nettype none
module tapr_datapath (
  input  logic                      clk,
  input  logic                      rst,
  input  tapr_pkg::dp_ctrl_t        ctrl,
  input  logic [tapr_pkg::IDX_W-1:0] req_index,
  output tapr_pkg::dp_stat_t        stat,
  output logic [7:0]                cell_char,
  output logic                      plotted,
  output logic                      frame_done
);
  import tapr_pkg::*;

  logic signed [7:0] vac, vas, vbc, vbs, tc, ts, rc, rs;
  logic [RING_W-1:0] ring_step;
  logic [TUBE_W-1:0] tube_step;
  logic signed [31:0] x1, x2, x3, x4, x5, x6, x7, acc, tmp, numx, numy;
  logic signed [31:0] px, py, rx, ry, sq, g;
  logic [3:0]        shade_idx;
  logic [IDX_W-1:0]  idx_r, clr_addr;
  logic [7:0]        res_char;
  logic              res_plot;

  logic [15:0] mem [CELLS];
  logic [15:0] rdata;
  logic        we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [15:0] wdata;

  logic signed [31:0] ma, mb, mp, cj32, cur_c, cur_s, mc, ms, dx, dy, dd, lum;
  logic signed [31:0] q, dz;
  logic signed [7:0]  zz;
  logic               div_done, depth_pass, idx_in, done_now;
  logic [IDX_W-1:0]   cell_addr;

  assign cj32 = 32'(tc) + 32'sd32;
  assign mp   = 32'(ma * mb);

  always_comb begin
    unique case (ctrl.rot)
      ROT_RING: begin cur_c = 32'(rc);  cur_s = 32'(rs);  end
      ROT_TUBE: begin cur_c = 32'(tc);  cur_s = 32'(ts);  end
      ROT_VA:   begin cur_c = 32'(vac); cur_s = 32'(vas); end
      default:  begin cur_c = 32'(vbc); cur_s = 32'(vbs); end
    endcase
    ms = (ctrl.rot == ROT_TUBE) ? cur_s + (cur_s <<< 1) : cur_s <<< 1;
    mc = (ctrl.rot == ROT_TUBE) ? cur_c + (cur_c <<< 1) : cur_c <<< 1;
    dx = (ctrl.rot == ROT_TUBE || ctrl.rot == ROT_VA) ? ms >>> 2 : ms >>> 3;
    dy = (ctrl.rot == ROT_TUBE || ctrl.rot == ROT_VA) ? mc >>> 2 : mc >>> 3;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctrl.op)
      OP_X1:  begin ma = 32'(rc);  mb = cj32;    end
      OP_X2:  begin ma = 32'(vac); mb = 32'(ts); end
      OP_X3:  begin ma = 32'(rs);  mb = cj32;    end
      OP_X4:  begin ma = 32'(vas); mb = x3;      end
      OP_X5:  begin ma = 32'(vas); mb = 32'(ts); end
      OP_X6:  begin ma = 32'(vac); mb = x3;      end
      OP_X7:  begin ma = 32'(tc);  mb = 32'(rs); end
      OP_NXA: begin ma = 32'(vbc); mb = x1;      end
      OP_NXB: begin ma = 32'(vbs); mb = x4;      end
      OP_NYA: begin ma = 32'(vbc); mb = x4;      end
      OP_NYB: begin ma = 32'(vbs); mb = x1;      end
      OP_L1:  begin ma = 32'(vac); mb = x7;      end
      OP_L2:  begin ma = 32'(vas); mb = x7;      end
      OP_L3:  begin ma = 32'(vbc); mb = tmp;     end
      OP_L4:  begin ma = 32'(tc);  mb = 32'(vbs); end
      OP_L5:  begin ma = 32'(rc);  mb = tmp;     end
      OP_R2:  begin ma = rx;       mb = rx;      end
      OP_R3:  begin ma = ry;       mb = ry;      end
      OP_R4:  begin ma = rx;       mb = g;       end
      OP_R5:  begin ma = ry;       mb = g;       end
      default: ;
    endcase
  end

  assign dd  = (ctrl.op == OP_NXB) ? acc - mp : acc + mp;
  assign lum = ((acc >>> 4) - x5) >>> 1;

  tapr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (ctrl.div_y ? numy : numx),
    .divisor  (x6),
    .done     (div_done),
    .quotient (q)
  );

  assign dz         = x6 - 32'(DEPTH_BASE);
  assign zz         = 8'(dz >>> 7);
  assign cell_addr  = IDX_W'(px) + IDX_W'(py) * IDX_W'(COLS);
  assign depth_pass = zz < $signed(rdata[7:0]);
  assign idx_in     = idx_r < IDX_W'(CELLS);
  assign done_now   = tube_step >= TUBE_W'(TUBE_STEPS);

  always_comb begin
    stat.x6_zero    = (x6 == 32'sd0);
    stat.in_grid    = (py < 32'(ROWS)) && (py > 32'sd0) && (px > 32'sd0)
                      && (px < 32'(COLS));
    stat.div_done   = div_done;
    stat.ring_wrap  = (ring_step == RING_W'(RING_STEPS - 1));
    stat.clr_last   = (clr_addr == IDX_W'(CELLS - 1));
    stat.frame_done = done_now;
  end

  // Memory port selection.
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = clr_addr;
    raddr = idx_r;
    wdata = {CHAR_SPACE, DEPTH_FAR};
    case (ctrl.op)
      OP_CLR:      we = 1'b1;
      OP_CELL_OUT: begin we = idx_in; waddr = idx_r; end
      OP_MWR_PLOT: begin
        we    = depth_pass;
        waddr = cell_addr;
        wdata = {shade_char(shade_idx), zz};
      end
      OP_MRD_PLOT: begin re = 1'b1; raddr = cell_addr; end
      OP_MRD_CELL: re = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Angle and loop state.
  always_ff @(posedge clk) begin
    if (rst) begin
      vac <= '0;  vas <= UNIT;
      vbc <= '0;  vbs <= UNIT;
      tc  <= UNIT; ts <= '0;
      rc  <= UNIT; rs <= '0;
      ring_step <= '0;
      tube_step <= '0;
      clr_addr  <= '0;
    end else begin
      case (ctrl.op)
        OP_R5: begin
          unique case (ctrl.rot)
            ROT_RING: begin rc  <= 8'(rx); rs  <= 8'(mp >>> 4); end
            ROT_TUBE: begin tc  <= 8'(rx); ts  <= 8'(mp >>> 4); end
            ROT_VA:   begin vac <= 8'(rx); vas <= 8'(mp >>> 4); end
            default:  begin vbc <= 8'(rx); vbs <= 8'(mp >>> 4); end
          endcase
        end
        OP_RING_ADV: begin
          if (stat.ring_wrap) begin
            ring_step <= '0;
            rc        <= UNIT;
            rs        <= '0;
            tube_step <= tube_step + TUBE_W'(1);
          end else begin
            ring_step <= ring_step + RING_W'(1);
          end
        end
        OP_FRAME: begin
          tc <= UNIT; ts <= '0;
          rc <= UNIT; rs <= '0;
          ring_step <= '0;
          tube_step <= '0;
          clr_addr  <= '0;
        end
        OP_CLR: clr_addr <= clr_addr + IDX_W'(1);
        default: ;
      endcase
    end
  end

  // Working registers of one point.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_X1:  x1 <= mp >>> 4;
      OP_X2:  x2 <= mp >>> 4;
      OP_X3:  x3 <= mp >>> 4;
      OP_X4:  x4 <= x2 - (mp >>> 4);
      OP_X5:  x5 <= mp >>> 4;
      OP_X6:  x6 <= 32'(DEPTH_BASE) + (x5 <<< 4) + mp;
      OP_X7:  x7 <= mp >>> 4;
      OP_NXA: acc <= mp;
      OP_NXB: numx <= (dd <<< 5) - (dd <<< 1);
      OP_NYA: acc <= mp;
      OP_NYB: numy <= (dd <<< 4) - dd;
      OP_L1:  acc <= -mp;
      OP_L2:  tmp <= ((-mp) >>> 4) + x2;
      OP_L3:  acc <= acc - mp;
      OP_L4:  tmp <= mp >>> 4;
      OP_L5:  acc <= acc - mp;
      OP_L6: begin
        if (lum < 32'sd0)       shade_idx <= 4'd0;
        else if (lum > 32'sd11) shade_idx <= 4'd11;
        else                    shade_idx <= 4'(lum);
      end
      OP_R1: begin
        rx <= cur_c - dx;
        ry <= cur_s + dy;
      end
      OP_R2: sq <= mp;
      OP_R3: g  <= (32'sd768 - sq - mp) >>> 5;
      OP_R4: rx <= mp >>> 4;
      OP_DIVX_GET: px <= 32'(CENTRE_X) + q;
      OP_DIVY_GET: py <= 32'(CENTRE_Y) + q;
      default: ;
    endcase
  end

  // Result of the current command and the output register.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LATCH: begin
        idx_r    <= req_index;
        res_char <= '0;
        res_plot <= 1'b0;
      end
      OP_MWR_PLOT: res_plot <= depth_pass;
      OP_CELL_OUT: begin
        if (col_zero(idx_r)) res_char <= CHAR_NL;
        else if (idx_in)     res_char <= rdata[15:8];
        else                 res_char <= CHAR_SPACE;
      end
      default: ;
    endcase
    if (ctrl.load_out) begin
      cell_char  <= res_char;
      plotted    <= res_plot;
      frame_done <= done_now;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/tapr_ctrl.sv @@
// Controller state machine: sequences the datapath micro-operations per command.
// Depends on tapr_pkg.
`default_nettype none
module tapr_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic [tapr_pkg::CMD_W-1:0] req_cmd,
  output logic                       req_ready,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  input  tapr_pkg::dp_stat_t         stat,
  output tapr_pkg::dp_ctrl_t         ctrl
);
  import tapr_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_CLEAR  = 13'b0000000000010,
    S_PLOT   = 13'b0000000000100,
    S_DIVX   = 13'b0000000001000,
    S_DIVY   = 13'b0000000010000,
    S_MRD    = 13'b0000000100000,
    S_MWR    = 13'b0000001000000,
    S_ROT    = 13'b0000010000000,
    S_ADV    = 13'b0000100000000,
    S_CRD    = 13'b0001000000000,
    S_CWR    = 13'b0010000000000,
    S_FRAME  = 13'b0100000000000,
    S_FINISH = 13'b1000000000000
  } state_t;

  state_t   state, state_next;
  logic [4:0] step, step_next;
  rot_sel_t rot, rot_next;
  logic     clr_reply, clr_reply_next;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    step_next      = step;
    rot_next       = rot;
    clr_reply_next = clr_reply;
    ctrl.op        = OP_NONE;
    ctrl.rot       = rot;
    ctrl.div_start = 1'b0;
    ctrl.div_y     = 1'b0;
    ctrl.load_out  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctrl.op = OP_LATCH;
          step_next = '0;
          case (req_cmd)
            CMD_PLOT:  state_next = stat.frame_done ? S_FINISH : S_PLOT;
            CMD_READ:  state_next = S_CRD;
            CMD_FRAME: begin
              rot_next   = ROT_VA;
              state_next = S_ROT;
            end
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_PLOT: begin
        ctrl.op = plot_op(step);
        if (step == PLOT_LAST) begin
          step_next = '0;
          if (stat.x6_zero) begin
            rot_next   = ROT_RING;
            state_next = S_ROT;
          end else begin
            ctrl.div_start = 1'b1;
            state_next     = S_DIVX;
          end
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_DIVX: begin
        if (stat.div_done) begin
          ctrl.op        = OP_DIVX_GET;
          ctrl.div_start = 1'b1;
          ctrl.div_y     = 1'b1;
          state_next     = S_DIVY;
        end
      end
      S_DIVY: begin
        if (stat.div_done) begin
          ctrl.op    = OP_DIVY_GET;
          state_next = S_MRD;
        end
      end
      S_MRD: begin
        if (stat.in_grid) begin
          ctrl.op    = OP_MRD_PLOT;
          state_next = S_MWR;
        end else begin
          rot_next   = ROT_RING;
          step_next  = '0;
          state_next = S_ROT;
        end
      end
      S_MWR: begin
        ctrl.op    = OP_MWR_PLOT;
        rot_next   = ROT_RING;
        step_next  = '0;
        state_next = S_ROT;
      end
      S_ROT: begin
        ctrl.op = rot_op(step);
        if (step == ROT_LAST) begin
          step_next = '0;
          unique case (rot)
            ROT_RING: state_next = S_ADV;
            ROT_TUBE: state_next = S_FINISH;
            ROT_VA:   rot_next   = ROT_VB;
            default:  state_next = S_FRAME;
          endcase
        end else begin
          step_next = step + 5'd1;
        end
      end
      S_ADV: begin
        ctrl.op = OP_RING_ADV;
        if (stat.ring_wrap) begin
          rot_next   = ROT_TUBE;
          step_next  = '0;
          state_next = S_ROT;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_CRD: begin
        ctrl.op    = OP_MRD_CELL;
        state_next = S_CWR;
      end
      S_CWR: begin
        ctrl.op    = OP_CELL_OUT;
        state_next = S_FINISH;
      end
      S_FRAME: begin
        ctrl.op        = OP_FRAME;
        clr_reply_next = 1'b1;
        state_next     = S_CLEAR;
      end
      S_CLEAR: begin
        ctrl.op = OP_CLR;
        if (stat.clr_last) begin
          clr_reply_next = 1'b0;
          state_next     = clr_reply ? S_FINISH : S_IDLE;
        end
      end
      S_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          ctrl.load_out = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      step      <= '0;
      rot       <= ROT_RING;
      clr_reply <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      rot       <= rot_next;
      clr_reply <= clr_reply_next;
      if (ctrl.load_out)  rsp_valid <= 1'b1;
      else if (rsp_ready) rsp_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/tapr_checker.sv @@
// Port-level checker of the torus point renderer, attached by bind.
// Depends on torus_ascii_point_renderer and its interfaces.
`default_nettype none
module tapr_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] cell_char,
  input logic       plotted
);
  // A waiting result beat is not dropped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid) else $error("result beat dropped");

  // Only a plot can report a write, and a plot never carries a character.
  a_plot_char: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && plotted |-> cell_char == 8'd0) else $error("plot with character");

  // The clearing pass after reset keeps the command channel closed.
  a_clear: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !req_ready) else $error("command taken during clearing");

  // Characters are zero, newline, or printable.
  a_char: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (cell_char == 8'd0 || cell_char == 8'd10 || cell_char >= 8'd32))
    else $error("bad character");
endmodule

bind torus_ascii_point_renderer tapr_checker u_tapr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .cell_char (rsp.cell_char),
  .plotted   (rsp.plotted)
);
`default_nettype wire
